@@ design/ecc3_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 Euler characteristic change core.
// No dependencies; imported by every module of the core.
package ecc3_pkg;

   // Geometry and sample format.
   localparam int MAX_WIDTH    = 1024;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS   = 11;
   localparam int HEIGHT_BITS  = 16;
   localparam int SAMPLE_BITS  = 32;
   localparam int EC_BITS      = 3;
   localparam int MIN_SIZE     = 3;

   // Register file layout: one 32-bit register per word.
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(1024);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(1024);

   // Request payload.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          frame_start;
   } req_type;

   // Result payload.
   typedef struct packed {
      logic signed [EC_BITS-1:0] ec_change;
      logic                      last_in_frame;
   } rsp_type;

   // Position of an accepted sample, handed from the scan counters to the stencil.
   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic                produce;
      logic                last;
   } pos_type;

endpackage

@@ design/ecc3_scan.sv @@
`timescale 1ns / 1ps
// Column and row counters of the raster scan, with frame size clamping.
// Depends on ecc3_pkg.
module ecc3_scan (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             frame_start,
   input  logic [ecc3_pkg::WIDTH_BITS-1:0]  frame_width,
   input  logic [ecc3_pkg::HEIGHT_BITS-1:0] frame_height,
   output ecc3_pkg::pos_type                pos
);
   import ecc3_pkg::*;

   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [WIDTH_BITS-1:0]  eff_w;
   logic [HEIGHT_BITS-1:0] eff_h;
   logic [WIDTH_BITS-1:0]  c0, c1, cn;
   logic [HEIGHT_BITS-1:0] r0, r;
   logic [HEIGHT_BITS:0]   r1, rn;
   logic                   wrap_c;

   // Clamp the programmed frame size to the supported range.
   always_comb begin
      if (frame_width < WIDTH_BITS'(MIN_SIZE)) begin
         eff_w = WIDTH_BITS'(MIN_SIZE);
      end else if (frame_width > WIDTH_BITS'(MAX_WIDTH)) begin
         eff_w = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         eff_w = frame_width;
      end
      eff_h = (frame_height < HEIGHT_BITS'(MIN_SIZE)) ? HEIGHT_BITS'(MIN_SIZE) : frame_height;
   end

   // Position of the incoming sample: frame start restarts, oversize counters wrap.
   always_comb begin
      c0     = frame_start ? '0 : {1'b0, col_ff};
      r0     = frame_start ? '0 : row_ff;
      wrap_c = (c0 >= eff_w);
      c1     = wrap_c ? '0 : c0;
      r1     = {1'b0, r0} + (HEIGHT_BITS+1)'(wrap_c);
      r      = (r1 >= {1'b0, eff_h}) ? '0 : r1[HEIGHT_BITS-1:0];

      pos.col     = c1[COL_BITS-1:0];
      pos.produce = (c1 >= WIDTH_BITS'(2)) && (r >= HEIGHT_BITS'(2));
      pos.last    = (c1 == eff_w - WIDTH_BITS'(1)) && (r == eff_h - HEIGHT_BITS'(1));
   end

   // Position after this sample.
   always_comb begin
      cn = c1 + WIDTH_BITS'(1);
      rn = {1'b0, r} + (HEIGHT_BITS+1)'(1);
      if (cn >= eff_w) begin
         col_in = '0;
         row_in = (rn >= {1'b0, eff_h}) ? '0 : rn[HEIGHT_BITS-1:0];
      end else begin
         col_in = cn[COL_BITS-1:0];
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ design/ecc3_stencil.sv @@
`timescale 1ns / 1ps
// Line buffer memory, 3x3 window and the edge/face count of the center pixel.
// Depends on ecc3_pkg.
module ecc3_stencil (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                issue,
   input  logic signed [ecc3_pkg::SAMPLE_BITS-1:0] sample,
   input  ecc3_pkg::pos_type                   pos,
   input  logic                                out_free,
   output logic                                in_stall,
   output logic                                res_valid,
   output ecc3_pkg::rsp_type                   res_data
);
   import ecc3_pkg::*;

   // Each entry holds {row before the previous row, previous row} of one column.
   logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
   logic [2*SAMPLE_BITS-1:0] rd_ff;
   logic [2*SAMPLE_BITS-1:0] fwd_data_ff;
   logic                     fwd_ff;
   logic [2*SAMPLE_BITS-1:0] rd_eff;

   logic                          s1_valid_ff;
   logic [COL_BITS-1:0]           s1_col_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          s1_produce_ff;
   logic                          s1_last_ff;
   logic                          advance;

   logic signed [SAMPLE_BITS-1:0] win_ff [6];
   logic signed [SAMPLE_BITS-1:0] top, mid, bot, c;
   logic                          gn, gw, ge, gs;
   logic [2:0]                    edges, faces;

   // The held item leaves at once if it makes no result, else once the output register can take its result.
   assign advance  = s1_valid_ff && (!s1_produce_ff || out_free);
   assign in_stall = s1_valid_ff && !advance;

   // A read that hits the column written at the same edge takes the new data.
   assign rd_eff = fwd_ff ? fwd_data_ff : rd_ff;
   assign top    = rd_eff[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign mid    = rd_eff[SAMPLE_BITS-1:0];
   assign bot    = s1_sample_ff;

   // Line buffer: read on issue, write back the shifted column on advance.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ff <= line_mem[pos.col];
      end
      if (advance) begin
         line_mem[s1_col_ff] <= {mid, bot};
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         fwd_data_ff <= {mid, bot};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (issue) begin
         fwd_ff <= advance && (pos.col == s1_col_ff);
      end
   end

   // Stage holding the item whose line buffer data is being read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (issue) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_col_ff     <= pos.col;
         s1_sample_ff  <= sample;
         s1_produce_ff <= pos.produce;
         s1_last_ff    <= pos.last;
      end
   end

   // Window columns shift left as each item leaves.
   always_ff @(posedge clock) begin
      if (advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= bot;
      end
   end

   // Count the greater 4-neighbors and the corner squares fully above the center.
   always_comb begin
      c  = win_ff[4];
      gn = win_ff[3] > c;
      gw = win_ff[1] > c;
      ge = mid > c;
      gs = win_ff[5] > c;
      edges = 3'(gn) + 3'(gw) + 3'(ge) + 3'(gs);
      faces = 3'(gn && gw && (win_ff[0] > c))
            + 3'(gn && ge && (top > c))
            + 3'(gw && gs && (win_ff[2] > c))
            + 3'(ge && gs && (bot > c));
      res_data.ec_change     = edges - faces - 3'd1;
      res_data.last_in_frame = s1_last_ff;
   end

   assign res_valid = advance && s1_produce_ff;

endmodule

@@ design/euler_char_change_3x3_core.sv @@
`timescale 1ns / 1ps
// Top level of the 3x3 Euler characteristic change core: register port,
// request handshake and result register. Depends on ecc3_pkg, ecc3_scan, ecc3_stencil.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_stall     req_type {sample, frame_start}
//   rsp_      out        rsp_valid / rsp_stall     rsp_type {ec_change, last_in_frame}
//   csr_      in/out     psel, penable, pready     frame_width, frame_height
//
// One request is accepted every cycle unless a blocked result stalls requests; the line
// buffer memory is read once and written once per cycle, which sets that rate. A result
// moves from the stencil stage register into the output register once that is free.
// Reset clears the scan counters and the handshake state and loads the frame size
// registers with 1024 x 1024; the line buffers and window are not cleared.
// A stalled result holds the pipeline; requests stall only while the result
// register is full and blocked.
module euler_char_change_3x3_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ecc3_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ecc3_pkg::rsp_type                  rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ecc3_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ecc3_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ecc3_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import ecc3_pkg::*;

   logic [WIDTH_BITS-1:0]  frame_width_ff;
   logic [HEIGHT_BITS-1:0] frame_height_ff;
   logic                   csr_write;
   logic                   accept;
   logic                   out_free;
   logic                   res_valid;
   rsp_type                res_data;
   pos_type                pos;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   // Register port: zero wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[WIDTH_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[HEIGHT_BITS-1:0];
            default:          frame_width_ff  <= frame_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_BITS'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_BITS'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Request handshake.
   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   ecc3_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .frame_start  (req_data.frame_start),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .pos          (pos)
   );

   ecc3_stencil u_stencil (
      .clock     (clock),
      .reset     (reset),
      .issue     (accept),
      .sample    (req_data.sample),
      .pos       (pos),
      .out_free  (out_free),
      .in_stall  (req_stall),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // A new result never lands on a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten");

   // Requests stall only behind a blocked result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a blocked result");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result pending after reset");
`endif

endmodule
